// ===== hdl/rbm_pkg.sv =====
// rbm_pkg: shared types, constants and tables for the rotated box mesh generator
// covers the corner write transaction, the color write, the geometry sequencer states
// and the corner order and sign tables; depends on nothing
package rbm_pkg;

	localparam int NUM_VERTS   = 36;
	localparam int NUM_CORNERS = 8;
	localparam int NUM_PRODS   = 9;
	localparam int VTX_W       = 6;
	localparam int CRN_W       = 3;

	// geometry sequencer states
	typedef enum logic [1:0] {
		GS_IDLE,
		GS_PROD,
		GS_CORNER,
		GS_DRAIN
	} rbm_gstate_t;

	// one corner position written into the corner memory
	typedef struct packed {
		logic             we;
		logic             bank;
		logic [CRN_W-1:0] corner;
		logic             last;
		logic [31:0]      x;
		logic [31:0]      y;
		logic [31:0]      z;
	} rbm_wr_t;

	// box color captured per memory bank
	typedef struct packed {
		logic        we;
		logic        bank;
		logic [23:0] rgb;
	} rbm_col_t;

	// corner emitted at each vertex slot, 12 triangles over six faces
	function automatic logic [CRN_W-1:0] corner_order(input logic [VTX_W-1:0] k);
		logic [CRN_W-1:0] c;
		unique case (k)
			6'd0:  c = 3'd3;
			6'd1:  c = 3'd1;
			6'd2:  c = 3'd0;
			6'd3:  c = 3'd0;
			6'd4:  c = 3'd2;
			6'd5:  c = 3'd3;
			6'd6:  c = 3'd6;
			6'd7:  c = 3'd4;
			6'd8:  c = 3'd5;
			6'd9:  c = 3'd5;
			6'd10: c = 3'd7;
			6'd11: c = 3'd6;
			6'd12: c = 3'd6;
			6'd13: c = 3'd2;
			6'd14: c = 3'd0;
			6'd15: c = 3'd0;
			6'd16: c = 3'd4;
			6'd17: c = 3'd6;
			6'd18: c = 3'd7;
			6'd19: c = 3'd5;
			6'd20: c = 3'd1;
			6'd21: c = 3'd1;
			6'd22: c = 3'd3;
			6'd23: c = 3'd7;
			6'd24: c = 3'd3;
			6'd25: c = 3'd2;
			6'd26: c = 3'd6;
			6'd27: c = 3'd6;
			6'd28: c = 3'd7;
			6'd29: c = 3'd3;
			6'd30: c = 3'd0;
			6'd31: c = 3'd1;
			6'd32: c = 3'd5;
			6'd33: c = 3'd5;
			6'd34: c = 3'd4;
			6'd35: c = 3'd0;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	// corner sign bits: bit0 x positive, bit1 y positive, bit2 z positive
	function automatic logic [2:0] corner_sign(input logic [CRN_W-1:0] c);
		logic [2:0] s;
		unique case (c)
			3'd0: s = 3'd2;
			3'd1: s = 3'd3;
			3'd2: s = 3'd0;
			3'd3: s = 3'd1;
			3'd4: s = 3'd6;
			3'd5: s = 3'd7;
			3'd6: s = 3'd4;
			3'd7: s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/rotated_box_mesh_generator.sv =====
// rotated_box_mesh_generator: one box in, 36 triangle-list vertices out; uses rbm_geom, rbm_emit
// throughput: one vertex per cycle while out_stall is low, set by the single read port of the
// corner memory; corner math runs on one shared 33x31 multiplier
// reset clears the sequencer, bank flags and valids; memory contents stay undefined, no clear pass
module rotated_box_mesh_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] size_x,
	input  logic signed [31:0] size_y,
	input  logic signed [31:0] size_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic        [23:0] color_rgb,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic signed [31:0] vertex_z,
	output logic        [7:0]  color_red,
	output logic        [7:0]  color_green,
	output logic        [7:0]  color_blue,
	output logic               last_vertex
);
	import rbm_pkg::*;

	rbm_wr_t    wr;
	rbm_col_t   col;
	logic [1:0] bank_free;

	// corner computation
	rbm_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.size_x    (size_x),
		.size_y    (size_y),
		.size_z    (size_z),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.color_rgb (color_rgb),
		.bank_free (bank_free),
		.wr        (wr),
		.col       (col)
	);

	// corner memory and vertex emission
	rbm_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.col         (col),
		.bank_free   (bank_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.last_vertex (last_vertex)
	);

endmodule

// ===== hdl/rbm_geom.sv =====
// rbm_geom: takes one box and computes its eight rotated, saturated corner positions
// one shared 33x31 multiplier forms the rotation terms, a two-stage corner pipeline writes memory
// depends on rbm_pkg
module rbm_geom (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic signed [31:0] size_x,
	input  logic signed [31:0] size_y,
	input  logic signed [31:0] size_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic        [23:0] color_rgb,
	input  logic        [1:0]  bank_free,
	output rbm_pkg::rbm_wr_t   wr,
	output rbm_pkg::rbm_col_t  col
);
	import rbm_pkg::*;

	typedef enum logic [1:0] {
		AOP_ADD,
		AOP_SUB,
		AOP_NEG
	} aop_t;

	rbm_gstate_t state_q, state_d;
	logic        accept;
	logic        prod_go;
	logic        corner_go;
	logic [3:0]  step_q;
	logic [CRN_W-1:0] corner_q;
	logic        wr_bank_q;

	// box operands
	logic signed [31:0] ctr_q [3];
	logic signed [30:0] h_q [3];
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;

	// matrix entry stage
	logic signed [15:0] ma, mb, na, nb;
	logic signed [31:0] pa, pb;
	logic signed [32:0] sa, sb, a_d;
	aop_t               aop;
	logic [1:0]         jsel;
	logic signed [32:0] a_s1;
	logic signed [30:0] hsel_s1;
	logic [3:0]         step_s1;
	logic               pvld_s1;
	logic signed [63:0] prod;
	logic signed [62:0] p_q [NUM_PRODS];

	// corner pipeline
	logic [2:0]         sg;
	logic signed [63:0] t_d [3];
	logic signed [31:0] off_d [3];
	logic signed [63:0] t_c1 [3];
	logic signed [31:0] off_c1 [3];
	logic [CRN_W-1:0]   corner_c1;
	logic               vld_c1;
	logic               last_c1;
	logic [31:0]        pos_d [3];
	logic               vld_c2;
	logic               bank_c2;
	logic [CRN_W-1:0]   corner_c2;
	logic               last_c2;
	logic [31:0]        pos_c2 [3];

	function automatic logic [31:0] sat32(input logic signed [38:0] v);
		if (v > 39'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -39'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		prod_go   = 1'b0;
		corner_go = 1'b0;
		in_stall  = 1'b1;
		unique case (state_q)
			GS_IDLE: begin
				in_stall = !bank_free[wr_bank_q];
				accept   = in_valid && bank_free[wr_bank_q];
				if (accept) state_d = GS_PROD;
			end
			GS_PROD: begin
				prod_go = (step_q != 4'(NUM_PRODS));
				if (step_q == 4'(NUM_PRODS)) state_d = GS_CORNER;
			end
			GS_CORNER: begin
				corner_go = 1'b1;
				if (corner_q == CRN_W'(NUM_CORNERS - 1)) state_d = GS_DRAIN;
			end
			GS_DRAIN: begin
				state_d = GS_IDLE;
			end
			default: begin
				state_d = GS_IDLE;
			end
		endcase
	end

	// step and corner counters, write bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			corner_q  <= '0;
			wr_bank_q <= 1'b0;
		end else begin
			if (accept)
				step_q <= '0;
			else if (state_q == GS_PROD)
				step_q <= step_q + 4'd1;
			if (accept)
				corner_q <= '0;
			else if (corner_go)
				corner_q <= corner_q + CRN_W'(1);
			if (state_q == GS_DRAIN)
				wr_bank_q <= !wr_bank_q;
		end
	end

	// capture box operands, half size is floor(size / 2)
	always_ff @(posedge clk) begin
		if (accept) begin
			ctr_q[0] <= center_x;
			ctr_q[1] <= center_y;
			ctr_q[2] <= center_z;
			h_q[0]   <= size_x[31:1];
			h_q[1]   <= size_y[31:1];
			h_q[2]   <= size_z[31:1];
			qw_q     <= quat_w;
			qx_q     <= quat_x;
			qy_q     <= quat_y;
			qz_q     <= quat_z;
		end
	end

	assign col.we   = accept;
	assign col.bank = wr_bank_q;
	assign col.rgb  = color_rgb;

	// rotation matrix entry for this step: w[u]x + [u]x^2, row major
	always_comb begin
		ma = '0; mb = '0; na = '0; nb = '0;
		aop  = AOP_ADD;
		jsel = 2'd0;
		case (step_q)
			4'd0: begin ma = qy_q; mb = qy_q; na = qz_q; nb = qz_q; aop = AOP_NEG; jsel = 2'd0; end
			4'd1: begin ma = qx_q; mb = qy_q; na = qw_q; nb = qz_q; aop = AOP_SUB; jsel = 2'd1; end
			4'd2: begin ma = qx_q; mb = qz_q; na = qw_q; nb = qy_q; aop = AOP_ADD; jsel = 2'd2; end
			4'd3: begin ma = qx_q; mb = qy_q; na = qw_q; nb = qz_q; aop = AOP_ADD; jsel = 2'd0; end
			4'd4: begin ma = qx_q; mb = qx_q; na = qz_q; nb = qz_q; aop = AOP_NEG; jsel = 2'd1; end
			4'd5: begin ma = qy_q; mb = qz_q; na = qw_q; nb = qx_q; aop = AOP_SUB; jsel = 2'd2; end
			4'd6: begin ma = qx_q; mb = qz_q; na = qw_q; nb = qy_q; aop = AOP_SUB; jsel = 2'd0; end
			4'd7: begin ma = qy_q; mb = qz_q; na = qw_q; nb = qx_q; aop = AOP_ADD; jsel = 2'd1; end
			4'd8: begin ma = qx_q; mb = qx_q; na = qy_q; nb = qy_q; aop = AOP_NEG; jsel = 2'd2; end
			default: begin ma = '0; mb = '0; na = '0; nb = '0; aop = AOP_ADD; jsel = 2'd0; end
		endcase
		pa = ma * mb;
		pb = na * nb;
		sa = 33'(pa);
		sb = 33'(pb);
		case (aop)
			AOP_SUB: a_d = sa - sb;
			AOP_NEG: a_d = -(sa + sb);
			default: a_d = sa + sb;
		endcase
	end

	// matrix entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= prod_go;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a_d;
		hsel_s1 <= h_q[jsel];
		step_s1 <= step_q;
	end

	// shared multiplier: entry times half size component
	assign prod = a_s1 * hsel_s1;

	always_ff @(posedge clk) begin
		if (pvld_s1)
			p_q[step_s1] <= prod[62:0];
	end

	// corner stage one: signed sums of the products and the signed offset
	always_comb begin
		logic signed [63:0] term;
		logic signed [63:0] acc;
		logic signed [31:0] hx;
		sg = corner_sign(corner_q);
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) begin
				term = 64'(p_q[3 * i + j]);
				acc  = sg[j] ? acc + term : acc - term;
			end
			t_d[i]   = acc;
			hx       = 32'(h_q[i]);
			off_d[i] = sg[i] ? hx : -hx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
		end else begin
			vld_c1 <= corner_go;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_c1[i]   <= t_d[i];
			off_c1[i] <= off_d[i];
		end
		corner_c1 <= corner_q;
		last_c1   <= (corner_q == CRN_W'(NUM_CORNERS - 1));
	end

	// corner stage two: round 2t to Q16.16, add offset and center, saturate
	always_comb begin
		logic signed [63:0] rsum;
		logic signed [36:0] rnd;
		logic signed [38:0] total;
		for (int i = 0; i < 3; i++) begin
			rsum     = t_c1[i] + 64'sd67108864;
			rnd      = rsum[63:27];
			total    = 39'(rnd) + 39'(off_c1[i]) + 39'(ctr_q[i]);
			pos_d[i] = sat32(total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c2 <= 1'b0;
		end else begin
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		bank_c2   <= wr_bank_q;
		corner_c2 <= corner_c1;
		last_c2   <= last_c1;
		for (int i = 0; i < 3; i++)
			pos_c2[i] <= pos_d[i];
	end

	// corner write transaction toward the memory
	assign wr = '{we: vld_c2, bank: bank_c2, corner: corner_c2, last: last_c2,
		x: pos_c2[0], y: pos_c2[1], z: pos_c2[2]};

endmodule

// ===== hdl/rbm_emit.sv =====
// rbm_emit: double-banked corner memory and the vertex emitter with its output register
// walks the 36-entry corner order of a full bank, one vertex per transaction
// depends on rbm_pkg
module rbm_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  rbm_pkg::rbm_wr_t   wr,
	input  rbm_pkg::rbm_col_t  col,
	output logic [1:0]         bank_free,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic signed [31:0] vertex_z,
	output logic        [7:0]  color_red,
	output logic        [7:0]  color_green,
	output logic        [7:0]  color_blue,
	output logic               last_vertex
);
	import rbm_pkg::*;

	localparam int MEM_DEPTH = 2 * NUM_CORNERS;

	logic [95:0]      corner_mem [MEM_DEPTH];
	logic [23:0]      col_q [2];
	logic [1:0]       full_q;
	logic             rd_bank_q;
	logic [VTX_W-1:0] vtx_q;
	logic             vtx_last;
	logic             issue;
	logic             out_ld;
	logic [CRN_W:0]   rd_addr;

	logic [95:0]      rd_s1;
	logic [23:0]      rgb_s1;
	logic             last_s1;
	logic             valid_s1;

	logic             valid_q;
	logic [95:0]      pos_q;
	logic [23:0]      rgb_q;
	logic             last_q;

	// read side flow control
	assign out_ld   = !valid_q || !out_stall;
	assign vtx_last = (vtx_q == VTX_W'(NUM_VERTS - 1));
	assign issue    = full_q[rd_bank_q] && (!valid_s1 || out_ld);
	assign rd_addr  = {rd_bank_q, corner_order(vtx_q)};

	// corner memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.we)
			corner_mem[{wr.bank, wr.corner}] <= {wr.x, wr.y, wr.z};
		if (issue)
			rd_s1 <= corner_mem[rd_addr];
	end

	// box color per bank
	always_ff @(posedge clk) begin
		if (col.we)
			col_q[col.bank] <= col.rgb;
	end

	// bank ownership: full once its last corner lands, free after its last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else begin
			if (wr.we && wr.last)
				full_q[wr.bank] <= 1'b1;
			if (issue && vtx_last)
				full_q[rd_bank_q] <= 1'b0;
		end
	end

	assign bank_free = ~full_q;

	// vertex counter and read bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q     <= '0;
			rd_bank_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			if (issue) begin
				vtx_q <= vtx_last ? '0 : vtx_q + VTX_W'(1);
				if (vtx_last)
					rd_bank_q <= !rd_bank_q;
			end
			if (issue)
				valid_s1 <= 1'b1;
			else if (out_ld)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rgb_s1  <= col_q[rd_bank_q];
			last_s1 <= vtx_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ld) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && valid_s1) begin
			pos_q  <= rd_s1;
			rgb_q  <= rgb_s1;
			last_q <= last_s1;
		end
	end

	assign out_valid   = valid_q;
	assign vertex_x    = pos_q[95:64];
	assign vertex_y    = pos_q[63:32];
	assign vertex_z    = pos_q[31:0];
	assign color_red   = rgb_q[23:16];
	assign color_green = rgb_q[15:8];
	assign color_blue  = rgb_q[7:0];
	assign last_vertex = last_q;

endmodule
